// ----- rtl/core/fcsg_pkg.sv -----
`default_nettype none

package fcsg_pkg;

    localparam int RADIUS_W      = 5;
    localparam int OFFSET_W      = 13;
    localparam int DIM_W         = 12;
    localparam int LINE_W        = 14;
    localparam int BOFF_W        = 26;
    localparam int BCNT_W        = 14;
    localparam int CENTER_W      = 14;
    localparam int COORD_W       = 15;
    localparam int HALF_W        = 12;
    localparam int Y_W           = 6;
    localparam int YSQ_W         = 11;
    localparam int RSQ_W         = 10;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 14;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 80;

    localparam logic [RADIUS_W-1:0] MAX_RADIUS = 5'd31;
    localparam int BYTES_PER_PIXEL = 3;

    localparam logic [DIM_W-1:0]  RESET_IMAGE_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0]  RESET_IMAGE_HEIGHT = 12'd480;
    localparam logic [LINE_W-1:0] RESET_LINE_BYTES   = 14'd1920;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES   = 2'd2;

    typedef logic [2:0] pc_t;

    localparam pc_t PC_IDLE   = 3'd0;
    localparam pc_t PC_CENTER = 3'd1;
    localparam pc_t PC_SEARCH = 3'd2;
    localparam pc_t PC_ABOVE  = 3'd3;
    localparam pc_t PC_BELOW  = 3'd4;

    typedef enum logic [1:0] {
        ROW_CENTER = 2'd0,
        ROW_ABOVE  = 2'd1,
        ROW_BELOW  = 2'd2
    } row_sel_t;

    typedef enum logic [1:0] {
        LAST_NONE  = 2'd0,
        LAST_RZERO = 2'd1,
        LAST_YEQR  = 2'd2
    } last_sel_t;

    typedef struct packed {
        logic      op_accept;
        logic      op_emit;
        logic      op_step;
        logic      op_search;
        row_sel_t  row_sel;
        last_sel_t last_sel;
        pc_t       next_pc;
        pc_t       last_pc;
    } ctrl_t;

    // microcode program
    function automatic ctrl_t prog_rom(input pc_t pc);
        ctrl_t cw;
        cw = '{op_accept: 1'b0, op_emit: 1'b0, op_step: 1'b0, op_search: 1'b0,
               row_sel: ROW_CENTER, last_sel: LAST_NONE,
               next_pc: PC_IDLE, last_pc: PC_IDLE};
        unique case (pc)
            PC_IDLE: begin
                cw.op_accept = 1'b1;
                cw.next_pc   = PC_CENTER;
            end
            PC_CENTER: begin
                cw.op_emit  = 1'b1;
                cw.op_step  = 1'b1;
                cw.row_sel  = ROW_CENTER;
                cw.last_sel = LAST_RZERO;
                cw.next_pc  = PC_SEARCH;
            end
            PC_SEARCH: begin
                cw.op_search = 1'b1;
                cw.next_pc   = PC_ABOVE;
            end
            PC_ABOVE: begin
                cw.op_emit = 1'b1;
                cw.row_sel = ROW_ABOVE;
                cw.next_pc = PC_BELOW;
            end
            PC_BELOW: begin
                cw.op_emit  = 1'b1;
                cw.op_step  = 1'b1;
                cw.row_sel  = ROW_BELOW;
                cw.last_sel = LAST_YEQR;
                cw.next_pc  = PC_SEARCH;
            end
            default: begin
                cw.next_pc = PC_IDLE;
            end
        endcase
        return cw;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_col(input logic signed [COORD_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({3'b000, hi})) begin
            res = hi;
        end else begin
            res = v[DIM_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/filled_circle_span_generator.sv -----
`default_nettype none

// channel   direction  fields (lowest bit first)
// s_        in         tdata: radius[4:0], offset_x[17:5], offset_y[30:18]
// m_        out        tdata: row, x_start, x_end, byte_offset, byte_count; tuser: visible;
//                      tlast: last
// cfg_      in         index 0 image_width, 1 image_height, 2 line_bytes
//
// a command is accepted in the idle step, then 2r+1 spans follow: the centre row, and per
// further row a search of one radius test per cycle followed by the spans above and below
// each span waits in its step while the output register is still held
// a new command is taken once the last span sits in the output register
// aresetn is synchronous, active low; the configuration registers return to 640 x 480, 1920 bytes
module filled_circle_span_generator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [fcsg_pkg::IN_TDATA_W-1:0]     s_tdata,   // radius, offset_x, offset_y
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [fcsg_pkg::OUT_TDATA_W-1:0]    m_tdata,   // row, x_start, x_end,
                                                                // byte_offset, byte_count
    output      logic                                m_tuser,   // visible
    output      logic                                m_tlast,
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [fcsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fcsg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fcsg_pkg::*;

    // configuration
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [LINE_W-1:0] line_reg;

    // sequencer and datapath
    pc_t                          pc_reg;
    pc_t                          pc_next;
    ctrl_t                        cw;
    logic [RADIUS_W-1:0]          r_reg;
    logic [RSQ_W-1:0]             rsq_reg;
    logic signed [CENTER_W-1:0]   cx_reg;
    logic signed [CENTER_W-1:0]   cy_reg;
    logic signed [HALF_W-1:0]     x0_reg;
    logic signed [HALF_W-1:0]     dx_reg;
    logic signed [HALF_W-1:0]     x1_reg;
    logic [Y_W-1:0]               y_reg;
    logic [YSQ_W-1:0]             ysq_reg;

    // output register
    logic                         m_tvalid_reg;
    logic [DIM_W-1:0]             row_reg;
    logic [DIM_W-1:0]             xs_reg;
    logic [DIM_W-1:0]             xe_reg;
    logic [BOFF_W-1:0]            boff_reg;
    logic [BCNT_W-1:0]            bcnt_reg;
    logic                         vis_reg;
    logic                         last_reg;

    // combinational
    logic [RADIUS_W-1:0]          in_radius;
    logic [RADIUS_W-1:0]          in_r_sat;
    logic signed [OFFSET_W-1:0]   in_off_x;
    logic signed [OFFSET_W-1:0]   in_off_y;
    logic                         out_free;
    logic                         search_more;
    logic [2*(HALF_W-1)-1:0]      x1_sq;
    logic [2*(HALF_W-1):0]        dist_sq;
    logic                         go;
    logic                         emit_last;
    logic signed [COORD_W-1:0]    row_s;
    logic signed [COORD_W-1:0]    xa_s;
    logic signed [COORD_W-1:0]    xb_s;
    logic [DIM_W-1:0]             hi_col;
    logic                         row_vis;
    logic [DIM_W-1:0]             xa_c;
    logic [DIM_W-1:0]             xb_c;
    logic [BOFF_W-1:0]            boff_c;
    logic [BCNT_W-1:0]            bcnt_c;
    logic [BCNT_W-1:0]            span_diff;

    assign cw        = prog_rom(pc_reg);
    assign cfg_ready = 1'b1;
    assign s_tready  = cw.op_accept;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign in_radius = s_tdata[RADIUS_W-1:0];
    assign in_off_x  = s_tdata[RADIUS_W +: OFFSET_W];
    assign in_off_y  = s_tdata[RADIUS_W+OFFSET_W +: OFFSET_W];
    assign in_r_sat  = (in_radius > MAX_RADIUS) ? MAX_RADIUS : in_radius;

    // radius test of the current candidate half-width
    assign x1_sq       = x1_reg[HALF_W-2:0] * x1_reg[HALF_W-2:0];
    assign dist_sq     = {1'b0, x1_sq} + {{(2*(HALF_W-1)+1-YSQ_W){1'b0}}, ysq_reg};
    assign search_more = (x1_reg > 12'sd0)
                         && (dist_sq > {{(2*(HALF_W-1)+1-RSQ_W){1'b0}}, rsq_reg});

    always_comb begin
        case (cw.last_sel)
            LAST_RZERO: emit_last = (r_reg == '0);
            LAST_YEQR:  emit_last = (y_reg == {1'b0, r_reg});
            default:    emit_last = 1'b0;
        endcase
    end

    always_comb begin
        if (cw.op_accept) begin
            go = s_tvalid;
        end else if (cw.op_emit) begin
            go = out_free;
        end else if (cw.op_search) begin
            go = !search_more;
        end else begin
            go = 1'b1;
        end
        if (!go) begin
            pc_next = pc_reg;
        end else if (cw.op_emit && emit_last) begin
            pc_next = cw.last_pc;
        end else begin
            pc_next = cw.next_pc;
        end
    end

    // span geometry and clamping
    always_comb begin
        case (cw.row_sel)
            ROW_ABOVE: row_s = COORD_W'(cy_reg) - COORD_W'(y_reg);
            ROW_BELOW: row_s = COORD_W'(cy_reg) + COORD_W'(y_reg);
            default:   row_s = COORD_W'(cy_reg);
        endcase
    end

    assign xa_s      = COORD_W'(cx_reg) - COORD_W'(x0_reg);
    assign xb_s      = COORD_W'(cx_reg) + COORD_W'(x0_reg);
    assign hi_col    = (width_reg == '0) ? '0 : width_reg - 12'd1;
    assign row_vis   = (row_s >= 0) && (row_s < $signed({3'b000, height_reg}));
    assign xa_c      = clamp_col(xa_s, hi_col);
    assign xb_c      = clamp_col(xb_s, hi_col);
    assign span_diff = {2'b00, xb_c} - {2'b00, xa_c};
    assign bcnt_c    = BCNT_W'(span_diff * BCNT_W'(BYTES_PER_PIXEL));
    assign boff_c    = BOFF_W'(BOFF_W'(xa_c) * BOFF_W'(BYTES_PER_PIXEL))
                       + BOFF_W'(BOFF_W'(line_reg) * BOFF_W'(row_s[DIM_W-1:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_IMAGE_WIDTH;
            height_reg <= RESET_IMAGE_HEIGHT;
            line_reg   <= RESET_LINE_BYTES;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_LINE_BYTES:   line_reg   <= cfg_data[LINE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= PC_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (cw.op_emit && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.op_accept && s_tvalid) begin
            r_reg   <= in_r_sat;
            rsq_reg <= in_r_sat * in_r_sat;
            cx_reg  <= CENTER_W'({1'b0, width_reg[DIM_W-1:1]}) + CENTER_W'(in_off_x);
            cy_reg  <= CENTER_W'({1'b0, height_reg[DIM_W-1:1]}) + CENTER_W'(in_off_y);
            x0_reg  <= HALF_W'(in_r_sat);
            dx_reg  <= '0;
            y_reg   <= '0;
            ysq_reg <= '0;
        end
        if (cw.op_step && go) begin
            y_reg   <= y_reg + 6'd1;
            ysq_reg <= ysq_reg + YSQ_W'({y_reg, 1'b1});
            x1_reg  <= x0_reg - dx_reg + 12'sd1;
        end
        if (cw.op_search) begin
            if (search_more) begin
                x1_reg <= x1_reg - 12'sd1;
            end else begin
                x0_reg <= x1_reg;
                dx_reg <= x0_reg - x1_reg;
            end
        end
        if (cw.op_emit && out_free) begin
            row_reg  <= row_vis ? row_s[DIM_W-1:0] : '0;
            xs_reg   <= row_vis ? xa_c : '0;
            xe_reg   <= row_vis ? xb_c : '0;
            boff_reg <= row_vis ? boff_c : '0;
            bcnt_reg <= row_vis ? bcnt_c : '0;
            vis_reg  <= row_vis;
            last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, bcnt_reg, boff_reg, xe_reg, xs_reg, row_reg};
    assign m_tuser  = vis_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_cmd_taken_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted twice in a row");

    a_search_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == PC_SEARCH && x1_reg <= 12'sd0) |=> (pc_reg == PC_ABOVE))
        else $error("search continued at non-positive half-width");

    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("hidden span carries nonzero fields");

    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (bcnt_reg == BCNT_W'(({2'b00, xe_reg} - {2'b00, xs_reg}) * 14'd3)))
        else $error("byte count does not match span ends");
`endif

endmodule

`default_nettype wire

// ----- verif/filled_circle_span_generator_checker.sv -----
module filled_circle_span_generator_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic [fcsg_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [fcsg_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  wire logic                                m_tuser,
    input  wire logic                                m_tlast,
    input  wire logic                                cfg_valid,
    input  wire logic                                cfg_ready,
    input  wire logic [fcsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fcsg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                       fail_count,
    output int                                       awaiting,
    output int                                       spans_checked
);

    typedef struct packed {
        logic [fcsg_pkg::DIM_W-1:0]  row;
        logic [fcsg_pkg::DIM_W-1:0]  x_start;
        logic [fcsg_pkg::DIM_W-1:0]  x_end;
        logic [fcsg_pkg::BOFF_W-1:0] byte_offset;
        logic [fcsg_pkg::BCNT_W-1:0] byte_count;
        logic                        visible;
        logic                        last;
    } span_t;

    logic [fcsg_pkg::DIM_W-1:0]  img_width;
    logic [fcsg_pkg::DIM_W-1:0]  img_height;
    logic [fcsg_pkg::LINE_W-1:0] row_bytes;
    span_t                       pending_spans[$];

    initial begin
        fail_count    = 0;
        awaiting      = 0;
        spans_checked = 0;
        img_width     = fcsg_pkg::RESET_IMAGE_WIDTH;
        img_height    = fcsg_pkg::RESET_IMAGE_HEIGHT;
        row_bytes     = fcsg_pkg::RESET_LINE_BYTES;
    end

    function automatic span_t clip_span(input int xa, input int xb, input int rw,
                                        input bit fin);
        span_t s;
        int    hi;
        s      = '0;
        s.last = fin;
        hi     = (img_width == 0) ? 0 : int'(img_width) - 1;
        if (rw < 0 || rw >= int'(img_height)) begin
            return s;
        end
        if (xa < 0) xa = 0;
        if (xa > hi) xa = hi;
        if (xb < 0) xb = 0;
        if (xb > hi) xb = hi;
        s.row         = rw[fcsg_pkg::DIM_W-1:0];
        s.x_start     = xa[fcsg_pkg::DIM_W-1:0];
        s.x_end       = xb[fcsg_pkg::DIM_W-1:0];
        s.byte_offset = fcsg_pkg::BOFF_W'(fcsg_pkg::BYTES_PER_PIXEL * xa
                                          + int'(row_bytes) * rw);
        s.byte_count  = fcsg_pkg::BCNT_W'(fcsg_pkg::BYTES_PER_PIXEL * (xb - xa));
        s.visible     = 1'b1;
        return s;
    endfunction

    // centre row, then above/below pairs with the incremental half-width search
    task automatic plan_circle_spans(input logic [fcsg_pkg::RADIUS_W-1:0] radius,
                                     input logic signed [fcsg_pkg::OFFSET_W-1:0] ox,
                                     input logic signed [fcsg_pkg::OFFSET_W-1:0] oy);
        int r;
        int cx;
        int cy;
        int rsq;
        int half;
        int step;
        int cand;
        r = radius;
        if (r > int'(fcsg_pkg::MAX_RADIUS)) r = fcsg_pkg::MAX_RADIUS;
        cx   = int'(img_width >> 1);
        cx   = cx + ox;
        cy   = int'(img_height >> 1);
        cy   = cy + oy;
        rsq  = r * r;
        half = r;
        step = 0;
        pending_spans.push_back(clip_span(cx - r, cx + r, cy, r == 0));
        for (int y = 1; y <= r; y++) begin
            cand = half - (step - 1);
            while (cand > 0 && cand * cand + y * y > rsq) cand--;
            step = half - cand;
            half = cand;
            pending_spans.push_back(clip_span(cx - half, cx + half, cy - y, 1'b0));
            pending_spans.push_back(clip_span(cx - half, cx + half, cy + y, y == r));
        end
    endtask

    always @(posedge aclk) begin : watch
        span_t got;
        span_t want;
        if (!aresetn) begin
            img_width  = fcsg_pkg::RESET_IMAGE_WIDTH;
            img_height = fcsg_pkg::RESET_IMAGE_HEIGHT;
            row_bytes  = fcsg_pkg::RESET_LINE_BYTES;
            pending_spans.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fcsg_pkg::REG_IMAGE_WIDTH:  img_width  = cfg_data[fcsg_pkg::DIM_W-1:0];
                    fcsg_pkg::REG_IMAGE_HEIGHT: img_height = cfg_data[fcsg_pkg::DIM_W-1:0];
                    fcsg_pkg::REG_LINE_BYTES:   row_bytes  = cfg_data[fcsg_pkg::LINE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                plan_circle_spans(s_tdata[4:0], s_tdata[17:5], s_tdata[30:18]);
            end
            if (m_tvalid && m_tready) begin
                got.row         = m_tdata[11:0];
                got.x_start     = m_tdata[23:12];
                got.x_end       = m_tdata[35:24];
                got.byte_offset = m_tdata[61:36];
                got.byte_count  = m_tdata[75:62];
                got.visible     = m_tuser;
                got.last        = m_tlast;
                spans_checked++;
                if (pending_spans.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected span: row %0d x %0d..%0d off %0d cnt %0d vis %0b last %0b",
                                 got.row, got.x_start, got.x_end, got.byte_offset,
                                 got.byte_count, got.visible, got.last);
                    end
                end else begin
                    want = pending_spans.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("span mismatch: expected row %0d x %0d..%0d off %0d cnt %0d",
                                     want.row, want.x_start, want.x_end, want.byte_offset,
                                     want.byte_count, " vis %0b last %0b", want.visible,
                                     want.last);
                            $display("               got      row %0d x %0d..%0d off %0d cnt %0d",
                                     got.row, got.x_start, got.x_end, got.byte_offset,
                                     got.byte_count, " vis %0b last %0b", got.visible,
                                     got.last);
                        end
                    end
                end
            end
        end
        awaiting = pending_spans.size();
    end

endmodule

// ----- verif/filled_circle_span_generator_tb.sv -----
module filled_circle_span_generator_tb;

    localparam int CYCLE_LIMIT     = 1500000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int SETTLE_CYCLES   = 200;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [fcsg_pkg::IN_TDATA_W-1:0]     s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [fcsg_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                                m_tuser;
    logic                                m_tlast;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [fcsg_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [fcsg_pkg::CFG_DATA_W-1:0]     cfg_data;

    int fail_count;
    int awaiting;
    int spans_checked;
    int cycle_count;
    int circles_sent;
    int reg_writes;
    int send_idle_pct;
    int recv_stall_pct;
    int cur_width;
    int cur_height;

    filled_circle_span_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    filled_circle_span_generator_checker span_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .awaiting      (awaiting),
        .spans_checked (spans_checked)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d spans outstanding", cycle_count, awaiting);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_circle(input int radius, input int ox, input int oy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, 13'(oy), 13'(ox), 5'(radius)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        circles_sent++;
    endtask

    // sender holds off until every span of earlier requests is back
    task automatic drain_spans();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (awaiting != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [fcsg_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= fcsg_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        reg_writes++;
    endtask

    // upper data bits above the 12-bit dimension are junk and must be ignored
    task automatic set_geometry(input int w, input int h, input int lb);
        write_reg(fcsg_pkg::REG_IMAGE_WIDTH, ($urandom_range(3) << 12) | w);
        write_reg(fcsg_pkg::REG_IMAGE_HEIGHT, ($urandom_range(3) << 12) | h);
        write_reg(fcsg_pkg::REG_LINE_BYTES, lb);
        cur_width  = w;
        cur_height = h;
    endtask

    function automatic int pick_offset(input int dim);
        int v;
        if ($urandom_range(9) < 4) begin
            v = int'($urandom_range(8191)) - 4096;
        end else begin
            v = int'($urandom_range(dim + 80)) - dim / 2 - 40;
            if (v < -4096) v = -4096;
            if (v > 4095) v = 4095;
        end
        return v;
    endfunction

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cycle_count    = 0;
        circles_sent   = 0;
        reg_writes     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_width      = 640;
        cur_height     = 480;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, at the reset geometry
        send_circle(0, 0, 0);
        send_circle(31, 0, 0);
        send_circle(1, 0, 0);
        send_circle(2, 0, 0);
        send_circle(5, -1, -1);
        send_circle(31, -4096, -4096);
        send_circle(31, 4095, 4095);
        send_circle(31, -320, -240);
        send_circle(31, 319, 239);
        send_circle(10, -340, 0);
        send_circle(0, -321, 0);
        send_circle(31, 0, -260);
        send_circle(16, 5, 250);
        send_circle(3, 2730, -2731);
        drain_spans();

        // zero width collapses every span, zero height hides every row
        write_reg(fcsg_pkg::REG_IMAGE_WIDTH, 0);
        cur_width = 0;
        send_circle(5, 3, 0);
        send_circle(31, -4096, 0);
        drain_spans();
        write_reg(fcsg_pkg::REG_IMAGE_HEIGHT, 0);
        send_circle(4, 0, 0);
        drain_spans();

        // largest geometry, byte offsets near the top of their range
        set_geometry(4095, 4095, 16383);
        send_circle(31, 2047, 2047);
        send_circle(31, -2047, -2047);
        send_circle(31, 2048, 2048);
        drain_spans();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_geometry(640, 480, 1920);
                1: set_geometry(4095, 4095, 16383);
                2: set_geometry(1, 1, 3);
                4, 5: set_geometry($urandom_range(1, 64), $urandom_range(1, 64),
                                   $urandom_range(3, 16383));
                default: set_geometry($urandom_range(1, 4095), $urandom_range(1, 4095),
                                      $urandom_range(3, 16383));
            endcase
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 87;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 87;
                end
                default: begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == ITEMS_PER_PHASE / 2) drain_spans();
                send_circle($urandom_range(31), pick_offset(cur_width),
                            pick_offset(cur_height));
            end
            drain_spans();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_spans();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("covered %0d circle requests and %0d returned spans, %0d register writes",
                 circles_sent, spans_checked, reg_writes);
        $display("geometries from zero and one pixel up to 4095 square, four flow-control mixes");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d span failures", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/fcsg_pkg.sv
rtl/core/filled_circle_span_generator.sv
verif/filled_circle_span_generator_checker.sv
verif/filled_circle_span_generator_tb.sv
